[rtl/dda_pkg.sv]
package dda_pkg;

	localparam int CLIP_SIZE = 1500;

	localparam int COORD_IN_W = 24;
	localparam int FRAC_SHIFT = 8;
	localparam int DIFF_W = COORD_IN_W + 1;
	localparam int POS_W = 32;
	localparam int POS_FRAC = 16;
	localparam int STEP_W = 18;
	localparam int STEPS_W = 17;
	localparam int OFF_W = 27;
	localparam int COLOR_W = 32;
	localparam int STRIDE_W = 16;
	localparam int BPP_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam int COORD_W = (CLIP_SIZE > 1) ? $clog2(CLIP_SIZE) : 1;
	localparam int MAC_CNT_W = (COORD_W > 1) ? $clog2(COORD_W) : 1;
	localparam int DIV_CNT_W = $clog2(STEPS_W);

	localparam logic signed [POS_W-1:0] POS_LO = -(POS_W'(1) << POS_FRAC);
	localparam logic signed [POS_W-1:0] POS_HI = POS_W'(CLIP_SIZE) << POS_FRAC;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd6000;
	localparam logic [BPP_W-1:0] BPP_RESET = 4'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_STRIDE = 2'd0,
		REG_BPP = 2'd1,
		REG_COLOR = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_STEP = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

[rtl/dda_line_rasterizer_unit.sv]
// DDA line stepper with clipped framebuffer addressing.
// The request channel (req_valid/req_ready) takes two kinds of item. A load
// item (req_type 0) sets up a new line from its Q15.8 endpoints and gives no
// result. A step item (req_type 1) gives exactly one item on the result
// channel (res_valid/res_ready): a pixel write when the current position lies
// inside the clip window, otherwise write_enable 0, with line_done marking the
// last step and any step past the line end. The cfg_we/cfg_index/cfg_data
// port writes registers. One item is worked on at a time. A load gets its
// two increments from one shared radix-2 divider that makes one quotient
// bit per cycle. A step that draws waits for the bit-serial offset
// multiplier that uses one bit of each coordinate per cycle; a step that
// draws nothing skips the multiplier.
// A finished result sits in the output register; the next request item is
// accepted while it waits. If the receiver stalls with a result still held,
// a further finished result waits inside until the register frees up.
// Reset clears the line state, restores the register defaults (stride 6000,
// four bytes per pixel, color 0) and leaves the result channel empty.
module dda_line_rasterizer_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic                                req_type,
	input  logic signed [dda_pkg::COORD_IN_W-1:0] start_x,
	input  logic signed [dda_pkg::COORD_IN_W-1:0] start_y,
	input  logic signed [dda_pkg::COORD_IN_W-1:0] end_x,
	input  logic signed [dda_pkg::COORD_IN_W-1:0] end_y,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic                                write_enable,
	output logic [dda_pkg::OFF_W-1:0]           pixel_offset,
	output logic [dda_pkg::COLOR_W-1:0]         pixel_color,
	output logic                                line_done,
	input  logic                                cfg_we,
	input  logic [dda_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dda_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import dda_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_DIVX,
		S_DIVY,
		S_MUL,
		S_EMIT
	} state_t;

	state_t state_q;

	logic [STRIDE_W-1:0] stride_q;
	logic [BPP_W-1:0]    bpp_q;
	logic [COLOR_W-1:0]  color_q;

	logic signed [POS_W-1:0] pos_x_q;
	logic signed [POS_W-1:0] pos_y_q;
	logic [STEP_W-1:0]       step_x_q;
	logic [STEP_W-1:0]       step_y_q;
	logic [STEPS_W-1:0]      steps_left_q;

	logic [DIFF_W-1:0]  div_mag_q;
	logic [DIFF_W-1:0]  mag_y_q;
	logic               neg_x_q;
	logic               neg_y_q;
	logic               div_start_q;
	logic               mac_start_q;
	logic [COORD_W-1:0] coord_x_q;
	logic [COORD_W-1:0] coord_y_q;

	logic               pend_we_q;
	logic               pend_done_q;
	logic [COLOR_W-1:0] pend_color_q;

	logic               res_valid_q;
	logic               write_enable_q;
	logic [OFF_W-1:0]   pixel_offset_q;
	logic [COLOR_W-1:0] pixel_color_q;
	logic               line_done_q;

	logic               accept;
	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;
	logic [DIFF_W-1:0]  mag_x;
	logic [DIFF_W-1:0]  mag_y;
	logic [STEPS_W-1:0] ax;
	logic [STEPS_W-1:0] ay;
	logic [STEPS_W-1:0] count;
	logic               in_x;
	logic               in_y;
	logic [STEP_W-1:0]  div_step;
	logic               out_free;

	logic [STEPS_W-1:0] quotient;
	logic [OFF_W-1:0]   mac_offset;
	unit_stat_t         div_stat;
	unit_stat_t         mac_stat;

	assign req_ready = (state_q == S_IDLE);
	assign accept = req_valid && req_ready;
	assign out_free = !res_valid_q || res_ready;

	assign dx = DIFF_W'(end_x) - DIFF_W'(start_x);
	assign dy = DIFF_W'(end_y) - DIFF_W'(start_y);
	assign mag_x = dx[DIFF_W-1] ? DIFF_W'(-dx) : dx;
	assign mag_y = dy[DIFF_W-1] ? DIFF_W'(-dy) : dy;
	assign ax = mag_x[DIFF_W-1:FRAC_SHIFT];
	assign ay = mag_y[DIFF_W-1:FRAC_SHIFT];
	assign count = (ax > ay) ? ax : ay;

	// A position just below zero still truncates to coordinate zero.
	assign in_x = (pos_x_q > POS_LO) && (pos_x_q < POS_HI);
	assign in_y = (pos_y_q > POS_LO) && (pos_y_q < POS_HI);

	assign div_step = (state_q == S_DIVX ? neg_x_q : neg_y_q)
		? STEP_W'(-{1'b0, quotient}) : {1'b0, quotient};

	dda_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (div_start_q),
		.dividend_mag (div_mag_q),
		.divisor      (steps_left_q),
		.quotient     (quotient),
		.stat         (div_stat)
	);

	dda_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (mac_start_q),
		.coord_x    (coord_x_q),
		.coord_y    (coord_y_q),
		.row_stride (stride_q),
		.bpp        (bpp_q),
		.offset     (mac_offset),
		.stat       (mac_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_RESET;
			bpp_q <= BPP_RESET;
			color_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW_STRIDE: stride_q <= cfg_data[STRIDE_W-1:0];
				REG_BPP:        bpp_q <= cfg_data[BPP_W-1:0];
				REG_COLOR:      color_q <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_x_q <= '0;
			pos_y_q <= '0;
			step_x_q <= '0;
			step_y_q <= '0;
			steps_left_q <= '0;
			div_mag_q <= '0;
			mag_y_q <= '0;
			neg_x_q <= 1'b0;
			neg_y_q <= 1'b0;
			div_start_q <= 1'b0;
			mac_start_q <= 1'b0;
			coord_x_q <= '0;
			coord_y_q <= '0;
			pend_we_q <= 1'b0;
			pend_done_q <= 1'b0;
			pend_color_q <= '0;
			res_valid_q <= 1'b0;
			write_enable_q <= 1'b0;
			pixel_offset_q <= '0;
			pixel_color_q <= '0;
			line_done_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			mac_start_q <= 1'b0;
			if (res_valid_q && res_ready && state_q != S_EMIT) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_kind_t'(req_type) == REQ_LOAD) begin
							pos_x_q <= {start_x, FRAC_SHIFT'(0)};
							pos_y_q <= {start_y, FRAC_SHIFT'(0)};
							steps_left_q <= count;
							step_x_q <= '0;
							step_y_q <= '0;
							div_mag_q <= mag_x;
							mag_y_q <= mag_y;
							neg_x_q <= dx[DIFF_W-1];
							neg_y_q <= dy[DIFF_W-1];
							if (count != '0) begin
								state_q <= S_LOAD;
							end
						end else if (steps_left_q == '0) begin
							pend_we_q <= 1'b0;
							pend_done_q <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							pos_x_q <= pos_x_q + POS_W'(signed'(step_x_q));
							pos_y_q <= pos_y_q + POS_W'(signed'(step_y_q));
							steps_left_q <= steps_left_q - 1'b1;
							pend_done_q <= (steps_left_q == STEPS_W'(1));
							pend_we_q <= in_x && in_y;
							pend_color_q <= color_q;
							coord_x_q <= pos_x_q[POS_W-1] ? '0 : pos_x_q[POS_FRAC +: COORD_W];
							coord_y_q <= pos_y_q[POS_W-1] ? '0 : pos_y_q[POS_FRAC +: COORD_W];
							if (in_x && in_y) begin
								mac_start_q <= 1'b1;
								state_q <= S_MUL;
							end else begin
								state_q <= S_EMIT;
							end
						end
					end
				end
				S_LOAD: begin
					div_start_q <= 1'b1;
					state_q <= S_DIVX;
				end
				S_DIVX: begin
					if (div_stat.done) begin
						step_x_q <= div_step;
						div_mag_q <= mag_y_q;
						div_start_q <= 1'b1;
						state_q <= S_DIVY;
					end
				end
				S_DIVY: begin
					if (div_stat.done) begin
						step_y_q <= div_step;
						state_q <= S_IDLE;
					end
				end
				S_MUL: begin
					if (mac_stat.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						write_enable_q <= pend_we_q;
						pixel_offset_q <= pend_we_q ? mac_offset : '0;
						pixel_color_q <= pend_we_q ? pend_color_q : '0;
						line_done_q <= pend_done_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign write_enable = write_enable_q;
	assign pixel_offset = pixel_offset_q;
	assign pixel_color = pixel_color_q;
	assign line_done = line_done_q;

	a_blank_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !write_enable_q |-> pixel_offset_q == '0 && pixel_color_q == '0)
		else $error("result without a write carries a nonzero offset or color");

	a_mac_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mac_stat.busy |-> state_q == S_MUL)
		else $error("offset multiplier runs outside the multiply state");

	a_div_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == S_DIVX || state_q == S_DIVY)
		else $error("divider runs outside the load sequence");

	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type == REQ_STEP && steps_left_q != '0
		|=> steps_left_q == $past(steps_left_q) - 1'b1)
		else $error("step item did not consume one step");

	a_empty_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type == REQ_STEP && steps_left_q == '0
		|=> steps_left_q == '0 && $stable(pos_x_q) && $stable(pos_y_q))
		else $error("step item past the line end changed the line state");

endmodule

[rtl/dda_div.sv]
module dda_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dda_pkg::DIFF_W-1:0]   dividend_mag,
	input  logic [dda_pkg::STEPS_W-1:0]  divisor,
	output logic [dda_pkg::STEPS_W-1:0]  quotient,
	output dda_pkg::unit_stat_t          stat
);
	import dda_pkg::*;

	// The dividend is dividend_mag shifted left by the fraction width. Its top
	// part is already below the divisor, so one quotient bit per cycle gives
	// the whole STEPS_W-bit quotient.
	logic [STEPS_W-1:0]   rem_q;
	logic [STEPS_W-1:0]   num_q;
	logic [STEPS_W-1:0]   div_q;
	logic [STEPS_W-1:0]   quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [STEPS_W:0] trial;
	logic             ge;

	assign trial = {rem_q, num_q[STEPS_W-1]};
	assign ge = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(STEPS_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= STEPS_W'(dividend_mag[DIFF_W-1:DIFF_W-STEPS_W+1]);
			num_q <= {dividend_mag[DIFF_W-STEPS_W:0], FRAC_SHIFT'(0)};
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? STEPS_W'(trial - {1'b0, div_q}) : trial[STEPS_W-1:0];
			num_q <= {num_q[STEPS_W-2:0], 1'b0};
			quo_q <= {quo_q[STEPS_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

[rtl/dda_mac.sv]
module dda_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dda_pkg::COORD_W-1:0]   coord_x,
	input  logic [dda_pkg::COORD_W-1:0]   coord_y,
	input  logic [dda_pkg::STRIDE_W-1:0]  row_stride,
	input  logic [dda_pkg::BPP_W-1:0]     bpp,
	output logic [dda_pkg::OFF_W-1:0]     offset,
	output dda_pkg::unit_stat_t           stat
);
	import dda_pkg::*;

	// Shift-and-add over one bit of each coordinate per cycle; the multiplicands
	// shift left as the coordinates shift right. Sums wrap at the offset width.
	logic [COORD_W-1:0]   xs_q;
	logic [COORD_W-1:0]   ys_q;
	logic [OFF_W-1:0]     str_q;
	logic [OFF_W-1:0]     bp_q;
	logic [OFF_W-1:0]     acc_q;
	logic [MAC_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [OFF_W-1:0] y_term;
	logic [OFF_W-1:0] x_term;

	assign y_term = ys_q[0] ? str_q : '0;
	assign x_term = xs_q[0] ? bp_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= MAC_CNT_W'(COORD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			xs_q <= coord_x;
			ys_q <= coord_y;
			str_q <= OFF_W'(row_stride);
			bp_q <= OFF_W'(bpp);
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + y_term + x_term;
			xs_q <= xs_q >> 1;
			ys_q <= ys_q >> 1;
			str_q <= str_q << 1;
			bp_q <= bp_q << 1;
		end
	end

	assign offset = acc_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule
